### sv/sijb_pkg.sv
// Package with the constants, types and codes of the sequence-indexed jitter buffer.
`default_nettype none

package sijb_pkg;

    localparam int SLOTS      = 256;
    localparam int SLOT_BYTES = 1500;

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int LEN_W  = $clog2(SLOT_BYTES + 1);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int SEQ_W  = 32;
    localparam int TIME_W = 64;
    localparam int PLEN_W = 16;

    typedef enum logic [1:0] {
        OP_ADD      = 2'd0,
        OP_GET_NEXT = 2'd1,
        OP_GET_SEQ  = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_MISS      = 2'd1,
        STAT_TOO_LARGE = 2'd2
    } status_t;

    typedef struct packed {
        logic [SEQ_W-1:0]  seq;
        logic [LEN_W-1:0]  len;
        logic [TIME_W-1:0] pres_time;
    } slot_entry_t;

    localparam int ENTRY_W = $bits(slot_entry_t);

endpackage

`default_nettype wire

### sv/sequence_indexed_jitter_buffer_core.sv
// Top level of the sequence-indexed jitter buffer descriptor table.
//
// Each input transaction is an add, a get of the next expected packet, or a get by
// sequence number; the slot is the sequence number modulo the slot count. Each input
// transaction produces exactly one output transaction carrying the status, the slot
// index for the external payload mover, the stored length and time on a hit that fits
// the capacity, and the expected sequence, valid count and total count afterwards.
// The input stage registers the transaction and starts the descriptor RAM read; from
// there the transaction writes the slot back and loads the result register, so one
// transaction is accepted every cycle while the receiver does not stall. The single
// descriptor RAM read and write per transaction sets that rate, and a write-to-read
// bypass covers a transaction that follows one to the same slot.
// When the receiver stalls, the result register holds its transaction and one more
// transaction waits in the input stage; the input channel then stalls.
// Reset clears all slot valid bits and the counters at once; the descriptor RAM needs
// no clearing, and the block accepts transactions in the first cycle after reset.
`default_nettype none

module sequence_indexed_jitter_buffer_core
    import sijb_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [1:0]        opcode,
    input  wire logic [SEQ_W-1:0]  seq_num,
    input  wire logic [PLEN_W-1:0] pkt_len,
    input  wire logic [TIME_W-1:0] pres_time,
    input  wire logic [PLEN_W-1:0] out_capacity,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [1:0]             status,
    output logic [7:0]             slot_index,
    output logic [10:0]            length_out,
    output logic [TIME_W-1:0]      pres_time_out,
    output logic [SEQ_W-1:0]       expected_next,
    output logic [8:0]             valid_count,
    output logic [SEQ_W-1:0]       total_count
);

    logic              in_full_reg;
    logic [1:0]        opcode_reg;
    logic [SEQ_W-1:0]  seq_reg;
    logic [PLEN_W-1:0] pkt_len_reg;
    logic [TIME_W-1:0] pres_time_reg;
    logic [PLEN_W-1:0] cap_reg;

    logic              byp_hit_reg;
    slot_entry_t       byp_data_reg;

    logic [SLOTS-1:0]  slot_valid_reg;
    logic [SLOTS-1:0]  slot_valid_next;
    logic [SEQ_W-1:0]  expected_reg;
    logic [SEQ_W-1:0]  expected_next_val;
    logic [CNT_W-1:0]  valid_slots_reg;
    logic [CNT_W-1:0]  valid_slots_next;
    logic [SEQ_W-1:0]  total_reg;
    logic [SEQ_W-1:0]  total_next;

    logic              out_valid_reg;
    logic [1:0]        status_reg;
    logic [1:0]        status_next;
    logic [7:0]        slot_index_reg;
    logic [10:0]       length_out_reg;
    logic [10:0]       length_out_next;
    logic [TIME_W-1:0] pres_time_out_reg;
    logic [TIME_W-1:0] pres_time_out_next;
    logic [SEQ_W-1:0]  expected_out_reg;
    logic [8:0]        valid_count_reg;
    logic [SEQ_W-1:0]  total_count_reg;

    logic              accept;
    logic              advance;
    logic [IDX_W-1:0]  in_idx;
    logic [IDX_W-1:0]  cur_idx;
    logic [ENTRY_W-1:0] ram_rdata;
    slot_entry_t       cur_entry;
    slot_entry_t       wr_entry;
    logic              ram_wr_en;
    logic              cur_valid;
    logic              tag_hit;
    logic [LEN_W-1:0]  clip_len;

    assign advance  = in_full_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_full_reg && out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign in_idx   = seq_num[IDX_W-1:0];
    assign cur_idx  = seq_reg[IDX_W-1:0];

    sijb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_desc_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (cur_idx),
        .wr_data (wr_entry),
        .rd_en   (accept),
        .rd_addr (in_idx),
        .rd_data (ram_rdata)
    );

    assign cur_entry = byp_hit_reg ? byp_data_reg : slot_entry_t'(ram_rdata);
    assign cur_valid = slot_valid_reg[cur_idx];
    assign tag_hit   = cur_valid && (cur_entry.seq == seq_reg);
    assign clip_len  = (pkt_len_reg < PLEN_W'(SLOT_BYTES)) ? pkt_len_reg[LEN_W-1:0]
                                                            : LEN_W'(SLOT_BYTES);

    always_comb
    begin
        wr_entry.seq       = seq_reg;
        wr_entry.len       = clip_len;
        wr_entry.pres_time = pres_time_reg;
        ram_wr_en          = 1'b0;
        slot_valid_next    = slot_valid_reg;
        expected_next_val  = expected_reg;
        valid_slots_next   = valid_slots_reg;
        total_next         = total_reg;
        status_next        = STAT_MISS;
        length_out_next    = '0;
        pres_time_out_next = '0;
        if (advance)
        begin
            unique case (opcode_t'(opcode_reg))
                OP_ADD:
                begin
                    ram_wr_en                = 1'b1;
                    slot_valid_next[cur_idx] = 1'b1;
                    if (!cur_valid)
                    begin
                        valid_slots_next = valid_slots_reg + CNT_W'(1);
                    end
                    total_next  = total_reg + SEQ_W'(1);
                    status_next = STAT_OK;
                end
                OP_GET_NEXT, OP_GET_SEQ:
                begin
                    if (tag_hit)
                    begin
                        slot_valid_next[cur_idx] = 1'b0;
                        valid_slots_next         = valid_slots_reg - CNT_W'(1);
                        if (PLEN_W'(cur_entry.len) <= cap_reg)
                        begin
                            status_next        = STAT_OK;
                            length_out_next    = 11'(cur_entry.len);
                            pres_time_out_next = cur_entry.pres_time;
                            if (opcode_t'(opcode_reg) == OP_GET_NEXT)
                            begin
                                expected_next_val = seq_reg + SEQ_W'(1);
                            end
                        end
                        else
                        begin
                            status_next = STAT_TOO_LARGE;
                        end
                    end
                end
                default:
                begin
                    status_next = STAT_MISS;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg     <= 1'b0;
            byp_hit_reg     <= 1'b0;
            slot_valid_reg  <= '0;
            expected_reg    <= '0;
            valid_slots_reg <= '0;
            total_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                in_full_reg <= 1'b1;
                byp_hit_reg <= ram_wr_en && (cur_idx == in_idx);
            end
            else if (advance)
            begin
                in_full_reg <= 1'b0;
            end
            slot_valid_reg  <= slot_valid_next;
            expected_reg    <= expected_next_val;
            valid_slots_reg <= valid_slots_next;
            total_reg       <= total_next;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            opcode_reg    <= opcode;
            seq_reg       <= seq_num;
            pkt_len_reg   <= pkt_len;
            pres_time_reg <= pres_time;
            cap_reg       <= out_capacity;
            byp_data_reg  <= wr_entry;
        end
        if (advance)
        begin
            status_reg        <= status_next;
            slot_index_reg    <= 8'(cur_idx);
            length_out_reg    <= length_out_next;
            pres_time_out_reg <= pres_time_out_next;
            expected_out_reg  <= expected_next_val;
            valid_count_reg   <= 9'(valid_slots_next);
            total_count_reg   <= total_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign slot_index    = slot_index_reg;
    assign length_out    = length_out_reg;
    assign pres_time_out = pres_time_out_reg;
    assign expected_next = expected_out_reg;
    assign valid_count   = valid_count_reg;
    assign total_count   = total_count_reg;

    a_count_matches_bits: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(slot_valid_reg) == int'(valid_slots_reg))
        else $error("valid slot count differs from the number of valid bits");

    a_hit_frees_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (opcode_reg == OP_GET_NEXT || opcode_reg == OP_GET_SEQ) && tag_hit)
        |=> !slot_valid_reg[$past(cur_idx)])
        else $error("a get hit did not free its slot");

    a_add_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && opcode_reg == OP_ADD) |=> (total_reg == $past(total_reg) + SEQ_W'(1)))
        else $error("an add did not advance the total count");

    a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_full_reg && out_valid_reg))
        else $error("input stalled with a free pipeline stage");

endmodule

`default_nettype wire

### sv/sijb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module sijb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### test/jitter_table_checker.sv
// Checker that predicts and compares every result of the jitter buffer descriptor table.
`timescale 1ns / 100ps

module jitter_table_checker
    import sijb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [1:0]        opcode,
    input  logic [SEQ_W-1:0]  seq_num,
    input  logic [PLEN_W-1:0] pkt_len,
    input  logic [TIME_W-1:0] pres_time,
    input  logic [PLEN_W-1:0] out_capacity,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [1:0]        status,
    input  logic [7:0]        slot_index,
    input  logic [10:0]       length_out,
    input  logic [TIME_W-1:0] pres_time_out,
    input  logic [SEQ_W-1:0]  expected_next,
    input  logic [8:0]        valid_count,
    input  logic [SEQ_W-1:0]  total_count,
    output int                error_count,
    output int                pending_count
);

    typedef struct packed {
        status_t           status;
        logic [7:0]        slot;
        logic [10:0]       length;
        logic [TIME_W-1:0] pres_time;
        logic [SEQ_W-1:0]  expected;
        logic [8:0]        live;
        logic [SEQ_W-1:0]  total;
    } table_result_t;

    logic                tag_valid [SLOTS];
    logic [SEQ_W-1:0]    tag_seq   [SLOTS];
    logic [LEN_W-1:0]    tag_len   [SLOTS];
    logic [TIME_W-1:0]   tag_time  [SLOTS];
    logic [SEQ_W-1:0]    next_expected;
    logic [CNT_W-1:0]    live_slots;
    logic [SEQ_W-1:0]    added_packets;
    table_result_t       pending_results [$];

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: %s mismatch: got %0h, expected %0h", $time, what, got, want);
        error_count++;
    endtask

    task automatic compare_field(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        if (got !== want)
        begin
            report_mismatch(what, got, want);
        end
    endtask

    function automatic table_result_t predict_table_op(input logic [1:0] op,
                                                       input logic [SEQ_W-1:0] seq,
                                                       input logic [PLEN_W-1:0] len,
                                                       input logic [TIME_W-1:0] ptime,
                                                       input logic [PLEN_W-1:0] cap);
        logic [IDX_W-1:0] idx;
        table_result_t    r;
        idx         = IDX_W'(seq % SLOTS);
        r.status    = STAT_MISS;
        r.slot      = 8'(seq % SLOTS);
        r.length    = '0;
        r.pres_time = '0;
        case (op)
            OP_ADD:
            begin
                if (!tag_valid[idx])
                begin
                    live_slots++;
                end
                tag_valid[idx] = 1'b1;
                tag_seq[idx]   = seq;
                tag_len[idx]   = (len < SLOT_BYTES) ? LEN_W'(len) : LEN_W'(SLOT_BYTES);
                tag_time[idx]  = ptime;
                added_packets++;
                r.status = STAT_OK;
            end
            OP_GET_NEXT, OP_GET_SEQ:
            begin
                if (tag_valid[idx] && tag_seq[idx] == seq)
                begin
                    tag_valid[idx] = 1'b0;
                    if (live_slots != 0)
                    begin
                        live_slots--;
                    end
                    if (tag_len[idx] <= cap)
                    begin
                        r.status    = STAT_OK;
                        r.length    = 11'(tag_len[idx]);
                        r.pres_time = tag_time[idx];
                        if (op == OP_GET_NEXT)
                        begin
                            next_expected = seq + 32'd1;
                        end
                    end
                    else
                    begin
                        r.status = STAT_TOO_LARGE;
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.expected = next_expected;
        r.live     = 9'(live_slots);
        r.total    = added_packets;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        table_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                tag_valid[i] = 1'b0;
            end
            next_expected = '0;
            live_slots    = '0;
            added_packets = '0;
            pending_results.delete();
            pending_count = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    report_mismatch("unexpected result transaction", status, 0);
                end
                else
                begin
                    want = pending_results.pop_front();
                    compare_field("status", status, want.status);
                    compare_field("slot_index", slot_index, want.slot);
                    compare_field("length_out", length_out, want.length);
                    compare_field("pres_time_out", pres_time_out, want.pres_time);
                    compare_field("expected_next", expected_next, want.expected);
                    compare_field("valid_count", valid_count, want.live);
                    compare_field("total_count", total_count, want.total);
                end
            end
            if (in_valid && !in_stall)
            begin
                pending_results.push_back(predict_table_op(opcode, seq_num, pkt_len,
                                                           pres_time, out_capacity));
            end
            pending_count = pending_results.size();
        end
    end

endmodule

### test/tb_sequence_indexed_jitter_buffer_core.sv
// Testbench top for the jitter buffer descriptor table: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb_sequence_indexed_jitter_buffer_core;
    import sijb_pkg::*;

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         RANDOM_ITEMS = 1900;
    localparam int         IDLE_LIMIT   = 4000;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         RECENT_DEPTH = 48;

    typedef enum int {
        RX_FLOW,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } rx_mode_t;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              in_valid     = 1'b0;
    logic              in_stall;
    logic [1:0]        opcode       = OP_ADD;
    logic [SEQ_W-1:0]  seq_num      = '0;
    logic [PLEN_W-1:0] pkt_len      = '0;
    logic [TIME_W-1:0] pres_time    = '0;
    logic [PLEN_W-1:0] out_capacity = '0;
    logic              out_valid;
    logic              out_stall    = 1'b0;
    logic [1:0]        status;
    logic [7:0]        slot_index;
    logic [10:0]       length_out;
    logic [TIME_W-1:0] pres_time_out;
    logic [SEQ_W-1:0]  expected_next;
    logic [8:0]        valid_count;
    logic [SEQ_W-1:0]  total_count;

    int                error_count;
    int                pending_count;
    int                idle_cycles = 0;
    rx_mode_t          rx_mode     = RX_FLOW;
    int                rx_left     = 0;
    int                rx_phase    = 0;

    bit                written [SLOTS];
    logic [SEQ_W-1:0]  recent_seqs [$];
    logic [SEQ_W-1:0]  stream_seq;
    int                burst_left  = 0;
    int                sent_items  = 0;
    int                add_weight  = 45;
    bit                gapless     = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    sequence_indexed_jitter_buffer_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .seq_num      (seq_num),
        .pkt_len      (pkt_len),
        .pres_time    (pres_time),
        .out_capacity (out_capacity),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .slot_index   (slot_index),
        .length_out   (length_out),
        .pres_time_out(pres_time_out),
        .expected_next(expected_next),
        .valid_count  (valid_count),
        .total_count  (total_count)
    );

    jitter_table_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .seq_num      (seq_num),
        .pkt_len      (pkt_len),
        .pres_time    (pres_time),
        .out_capacity (out_capacity),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .slot_index   (slot_index),
        .length_out   (length_out),
        .pres_time_out(pres_time_out),
        .expected_next(expected_next),
        .valid_count  (valid_count),
        .total_count  (total_count),
        .error_count  (error_count),
        .pending_count(pending_count)
    );

    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(3));
            rx_left = $urandom_range(256, 32);
        end
        rx_left--;
        rx_phase++;
        case (rx_mode)
            RX_FLOW:     out_stall = 1'b0;
            RX_LIGHT:    out_stall = ($urandom_range(3) == 0);
            RX_HEAVY:    out_stall = ($urandom_range(3) != 0);
            default:     out_stall = ((rx_phase % 7) < 3);
        endcase
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles == IDLE_LIMIT)
        begin
            $display("Watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [TIME_W-1:0] random_time();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [PLEN_W-1:0] random_length();
        int pick;
        pick = $urandom_range(19);
        if (pick < 12)
        begin
            return PLEN_W'($urandom_range(SLOT_BYTES, 40));
        end
        else if (pick < 14)
        begin
            return PLEN_W'($urandom_range(40, 0));
        end
        else if (pick < 17)
        begin
            return PLEN_W'($urandom_range(SLOT_BYTES + 100, SLOT_BYTES - 100));
        end
        return PLEN_W'($urandom_range(65535, 0));
    endfunction

    function automatic logic [PLEN_W-1:0] random_capacity();
        int pick;
        pick = $urandom_range(19);
        if (pick < 12)
        begin
            return PLEN_W'($urandom_range(65535, SLOT_BYTES));
        end
        else if (pick < 18)
        begin
            return PLEN_W'($urandom_range(SLOT_BYTES + 100, 0));
        end
        else if (pick == 18)
        begin
            return '0;
        end
        return '1;
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [SEQ_W-1:0] seq,
                             input logic [PLEN_W-1:0] len, input logic [TIME_W-1:0] ptime,
                             input logic [PLEN_W-1:0] cap);
        in_valid     = 1'b1;
        opcode       = op;
        seq_num      = seq;
        pkt_len      = len;
        pres_time    = ptime;
        out_capacity = cap;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        if (op == OP_ADD)
        begin
            written[seq % SLOTS] = 1'b1;
        end
    endtask

    task automatic pause_sender(input int cycles);
        in_valid     = 1'b0;
        opcode       = 2'($urandom_range(3));
        seq_num      = $urandom;
        pkt_len      = PLEN_W'($urandom);
        pres_time    = random_time();
        out_capacity = PLEN_W'($urandom);
        repeat (cycles) @(negedge clk);
    endtask

    task automatic wait_for_results();
        in_valid = 1'b0;
        while (pending_count != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic pace_sender();
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(40, 1);
            if (!gapless && $urandom_range(3) != 0)
            begin
                pause_sender($urandom_range(12, 1));
            end
        end
        burst_left--;
    endtask

    task automatic send_add();
        logic [SEQ_W-1:0] seq;
        int               pick;
        pick = $urandom_range(19);
        if (pick < 14)
        begin
            seq = stream_seq;
            stream_seq++;
        end
        else if (pick < 16)
        begin
            stream_seq += $urandom_range(5, 2);
            seq = stream_seq;
        end
        else if (pick < 18)
        begin
            seq = stream_seq - $urandom_range(40, 1);
        end
        else
        begin
            seq = $urandom;
        end
        if (recent_seqs.size() == RECENT_DEPTH)
        begin
            void'(recent_seqs.pop_front());
        end
        recent_seqs.push_back(seq);
        send_item(OP_ADD, seq, random_length(), random_time(), PLEN_W'($urandom));
        sent_items++;
    endtask

    task automatic send_get(input logic [1:0] op);
        logic [SEQ_W-1:0] seq;
        int               pos;
        int               pick;
        pick = $urandom_range(9);
        if (pick < 4)
        begin
            pos = recent_seqs.size() - 1;
        end
        else if (pick < 7)
        begin
            pos = 0;
        end
        else
        begin
            pos = $urandom_range(recent_seqs.size() - 1);
        end
        seq = recent_seqs[pos];
        recent_seqs.delete(pos);
        if ($urandom_range(9) == 0)
        begin
            seq ^= 32'd1 << (IDX_W + $urandom_range(SEQ_W - IDX_W - 1));
        end
        send_item(op, seq, PLEN_W'($urandom), random_time(), random_capacity());
        sent_items++;
    endtask

    initial
    begin
        logic [SEQ_W-1:0] seq;
        int               choice;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_item(OP_ADD, 32'h0000_0000, 16'h0000, 64'h0, 16'h0000);
        send_item(OP_GET_SEQ, 32'h0000_0000, 16'hFFFF, 64'h0, 16'h0000);
        send_item(OP_GET_SEQ, 32'h0000_0000, 16'h0000, 64'h0, 16'hFFFF);
        send_item(OP_ADD, 32'hFFFF_FFFF, 16'hFFFF, '1, 16'hFFFF);
        send_item(OP_GET_NEXT, 32'hFFFF_FFFF, 16'h0000, 64'h0, 16'd1499);
        send_item(OP_GET_NEXT, 32'hFFFF_FFFF, 16'h0000, 64'h0, 16'hFFFF);
        send_item(OP_ADD, 32'hFFFF_FFFF, 16'd1500, 64'h0123_4567_89AB_CDEF, 16'h0000);
        send_item(OP_GET_NEXT, 32'hFFFF_FFFF, 16'h0000, 64'h0, 16'd1500);
        send_item(OP_ADD, 32'h0000_0100, 16'd1501, 64'hFEDC_BA98_7654_3210, 16'h0000);
        send_item(OP_ADD, 32'h0000_0200, 16'd1, 64'h5555_5555_5555_5555, 16'h0000);
        send_item(OP_GET_SEQ, 32'h0000_0100, 16'h0000, 64'h0, 16'hFFFF);
        send_item(OP_UNUSED, 32'h0000_0200, 16'hFFFF, '1, 16'hFFFF);
        send_item(OP_GET_NEXT, 32'h0000_0200, 16'h0000, 64'h0, 16'd1);
        send_item(OP_ADD, 32'hAAAA_AA55, 16'h5555, 64'hAAAA_AAAA_AAAA_AAAA, 16'h5555);
        send_item(OP_ADD, 32'h5555_55AA, 16'hAAAA, 64'h5555_5555_5555_5555, 16'hAAAA);
        send_item(OP_GET_SEQ, 32'hAAAA_AA55, 16'h0000, 64'h0, 16'hAAAA);
        send_item(OP_GET_NEXT, 32'h5555_55AA, 16'h0000, 64'h0, 16'd1499);
        send_item(OP_ADD, 32'd7, 16'd1500, 64'h8000_0000_0000_0001, 16'h0000);
        send_item(OP_GET_NEXT, 32'd7, 16'h0000, 64'h0, 16'd1500);
        send_item(OP_ADD, 32'h0000_0107, 16'd20, 64'h0000_0001_0000_0000, 16'h0000);
        send_item(OP_GET_SEQ, 32'd7, 16'h0000, 64'h0, 16'hFFFF);
        send_item(OP_GET_SEQ, 32'h0000_0107, 16'h0000, 64'h0, 16'd19);

        wait_for_results();

        stream_seq = $urandom;
        for (int k = 0; k < SLOTS + 20; k++)
        begin
            pace_sender();
            send_add();
        end

        while (sent_items < RANDOM_ITEMS)
        begin
            if (sent_items % 150 == 0)
            begin
                case ($urandom_range(2))
                    0:       add_weight = 15;
                    1:       add_weight = 45;
                    default: add_weight = 75;
                endcase
            end
            gapless = (sent_items >= 1200 && sent_items < 1400);
            if (sent_items == 900 || $urandom_range(299) == 0)
            begin
                wait_for_results();
            end
            pace_sender();
            choice = $urandom_range(99);
            if (choice < add_weight || recent_seqs.size() == 0)
            begin
                send_add();
            end
            else if (choice < 90)
            begin
                send_get(($urandom_range(1) == 0) ? OP_GET_NEXT : OP_GET_SEQ);
            end
            else if (choice < 97)
            begin
                seq = $urandom;
                if (written[seq % SLOTS])
                begin
                    send_item(($urandom_range(1) == 0) ? OP_GET_NEXT : OP_GET_SEQ, seq,
                              PLEN_W'($urandom), random_time(), random_capacity());
                    sent_items++;
                end
                else
                begin
                    send_add();
                end
            end
            else
            begin
                send_item(OP_UNUSED, recent_seqs[$], PLEN_W'($urandom), random_time(),
                          PLEN_W'($urandom));
            end
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### filelist.f
sv/sijb_pkg.sv
sv/sijb_ram.sv
sv/sequence_indexed_jitter_buffer_core.sv
test/jitter_table_checker.sv
test/tb_sequence_indexed_jitter_buffer_core.sv
